### rtl/vatt_pkg.sv
package vatt_pkg;

  localparam int IN_W    = 21;
  localparam int ANGLE_W = 10;

  localparam logic [ANGLE_W-1:0] ZERO_ANGLE = 10'd512;

  // octant base in quarter turns
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } vatt_quad_t;

  typedef struct packed {
    logic       zero;
    logic       sub;
    vatt_quad_t quad;
  } vatt_side_t;

endpackage

### rtl/vatt_prep.sv
module vatt_prep #(
  parameter int CB    = 21,
  parameter int T     = 1024,
  parameter int NUM_W = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [vatt_pkg::IN_W-1:0]       in_vec_x,
  input  logic signed [vatt_pkg::IN_W-1:0]       in_vec_y,
  output logic                                   v_o,
  output logic [NUM_W-1:0]                       num_o,
  output logic [CB-1:0]                          den_o,
  output vatt_pkg::vatt_side_t                   side_o
);

  localparam int W = vatt_pkg::IN_W;
  localparam int HI = (1 << (CB - 1)) - 1;
  localparam int LO = -(1 << (CB - 1));
  localparam logic signed [W-1:0] HI_V = W'(HI);
  localparam logic signed [W-1:0] LO_V = W'(LO);

  logic signed [W-1:0]   x_sat, y_sat;
  logic signed [W:0]     x_wide, y_wide;
  logic [CB-1:0]         ax, ay, mag_min, mag_max;
  logic                  x_neg, y_neg, x_big, zero;
  vatt_pkg::vatt_side_t  side_nxt;
  logic [NUM_W-1:0]      num_nxt;
  logic [CB-1:0]         den_nxt;

  logic                  v_r;
  logic [NUM_W-1:0]      num_r;
  logic [CB-1:0]         den_r;
  vatt_pkg::vatt_side_t  side_r;

  always_comb begin
    x_sat = (in_vec_x > HI_V) ? HI_V : ((in_vec_x < LO_V) ? LO_V : in_vec_x);
    y_sat = (in_vec_y > HI_V) ? HI_V : ((in_vec_y < LO_V) ? LO_V : in_vec_y);
    x_wide = (W+1)'(x_sat);
    y_wide = (W+1)'(y_sat);
    x_neg = x_sat[W-1];
    y_neg = y_sat[W-1];
    ax = CB'(x_neg ? -x_wide : x_wide);
    ay = CB'(y_neg ? -y_wide : y_wide);
    zero = (ax == '0) && (ay == '0);
    x_big = ax > ay;
    mag_min = x_big ? ay : ax;
    mag_max = x_big ? ax : ay;
    side_nxt.zero = zero;
    if (x_big) begin
      side_nxt.quad = x_neg ? vatt_pkg::QUAD_3 : vatt_pkg::QUAD_1;
      side_nxt.sub  = x_neg != y_neg;
    end else begin
      side_nxt.quad = y_neg ? vatt_pkg::QUAD_0 : vatt_pkg::QUAD_2;
      side_nxt.sub  = x_neg == y_neg;
    end
    num_nxt = NUM_W'(mag_min) * NUM_W'(T);
    // keep the divider away from a zero divisor
    den_nxt = zero ? CB'(1) : mag_max;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign v_o    = v_r;
  assign num_o  = num_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

### rtl/vatt_div_cell.sv
module vatt_div_cell #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 21,
  parameter int QB    = 11,
  parameter int BIT   = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_i,
  input  logic [NUM_W-1:0]      rem_i,
  input  logic [DEN_W-1:0]      den_i,
  input  logic [QB-1:0]         q_i,
  input  vatt_pkg::vatt_side_t  side_i,
  output logic                  v_o,
  output logic [NUM_W-1:0]      rem_o,
  output logic [DEN_W-1:0]      den_o,
  output logic [QB-1:0]         q_o,
  output vatt_pkg::vatt_side_t  side_o
);

  logic [NUM_W-1:0]      shifted;
  logic                  take;
  logic [NUM_W-1:0]      rem_nxt;
  logic [QB-1:0]         q_nxt;

  logic                  v_r;
  logic [NUM_W-1:0]      rem_r;
  logic [DEN_W-1:0]      den_r;
  logic [QB-1:0]         q_r;
  vatt_pkg::vatt_side_t  side_r;

  // one restoring step: quotient bit BIT
  always_comb begin
    shifted = NUM_W'(den_i) << BIT;
    take    = rem_i >= shifted;
    rem_nxt = take ? rem_i - shifted : rem_i;
    q_nxt   = take ? (q_i | (QB'(1) << BIT)) : q_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_i;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign q_o    = q_r;
  assign side_o = side_r;

  // remainder must stay below the divisor at this bit weight
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> rem_r < (NUM_W'(den_r) << BIT))
    else $error("divider remainder out of range");

endmodule

### rtl/vatt_rom.sv
module vatt_rom #(
  parameter int ANGLE_STEPS = 1024,
  parameter int TABLE_SIZE  = 1024,
  parameter int AW          = 10,
  parameter int IDX_W       = 11
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IDX_W-1:0]  addr,
  output logic [AW-1:0]     data
);

  localparam int FRAC = 52;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC;

  typedef logic [AW-1:0] rom_tab_t [TABLE_SIZE+2];

  // shift and subtract, quotient in the upper half, remainder in the lower
  function automatic logic [127:0] udivmod(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return {q, r};
  endfunction

  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] qr;
    qr = udivmod(a, b);
    return qr[127:64];
  endfunction

  function automatic logic [63:0] umod(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] qr;
    qr = udivmod(a, b);
    return qr[63:0];
  endfunction

  // (a*b) >> 52, exact floor
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] m26, a1, a0, b1, b0, mid;
    m26 = (64'd1 << 26) - 64'd1;
    a1 = a >> 26;
    a0 = a & m26;
    b1 = b >> 26;
    b0 = b & m26;
    mid = a1 * b0 + a0 * b1 + ((a0 * b0) >> 26);
    return a1 * b1 + (mid >> 26);
  endfunction

  // nearest 24 significant bits, ties to even
  function automatic logic [63:0] round24(input logic [63:0] v);
    logic [63:0] t, q, rem, half;
    int k;
    if (v < (64'd1 << 24)) return v;
    t = v;
    k = 0;
    while (t >= (64'd1 << 24)) begin
      t = t >> 1;
      k = k + 1;
    end
    q = v >> k;
    rem = v & ((64'd1 << k) - 64'd1);
    half = 64'd1 << (k - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q << k;
  endfunction

  // trunc(tan(a) * TABLE_SIZE), a in Q52
  function automatic logic [63:0] tan_scaled(input logic [63:0] a);
    logic [63:0] a2, s, c, st, ct, n;
    logic neg, done;
    a2 = qmul(a, a);
    s = a;
    c = ONE_Q - (a2 >> 1);
    st = a;
    ct = a2 >> 1;
    neg = 1'b1;
    done = 1'b0;
    for (n = 64'd1; n < 64'd40 && !done; n = n + 64'd1) begin
      st = udiv(qmul(st, a2), (64'd2 * n) * (64'd2 * n + 64'd1));
      ct = udiv(qmul(ct, a2), (64'd2 * n + 64'd1) * (64'd2 * n + 64'd2));
      if (neg) begin
        s = s - st;
        c = c + ct;
      end else begin
        s = s + st;
        c = c - ct;
      end
      neg = !neg;
      if (st == 64'd0 && ct == 64'd0) done = 1'b1;
    end
    if (c == 64'd0) return '1;
    return udiv(s * 64'(TABLE_SIZE), c);
  endfunction

  // entry i: smallest angle step whose scaled tangent reaches i
  function automatic rom_tab_t build_rom();
    rom_tab_t tab;
    logic [63:0] den, m, r, d, cur, p;
    int e;
    den = 64'd100 * 64'(ANGLE_STEPS);
    e = 0;
    while (udiv(64'd628 << e, den) < (64'd1 << 23) && e < 50) e = e + 1;
    m = udiv(64'd628 << e, den);
    r = umod(64'd628 << e, den);
    if (64'd2 * r >= den) m = m + 64'd1;
    if (m >= (64'd1 << 24)) begin
      m = m >> 1;
      e = e - 1;
    end
    d = 64'd0;
    cur = 64'd0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      while (cur < 64'(i) && d < 64'd4 * 64'(ANGLE_STEPS)) begin
        d = d + 64'd1;
        p = round24(d * m);
        p = (e <= FRAC) ? (p << (FRAC - e)) : (p >> (e - FRAC));
        cur = (p >= ONE_Q + (ONE_Q >> 1)) ? '1 : tan_scaled(p);
      end
      tab[i] = AW'(d);
    end
    // end entries; only the value modulo the turn matters
    tab[TABLE_SIZE]     = AW'(128);
    tab[TABLE_SIZE + 1] = AW'(128);
    return tab;
  endfunction

  localparam rom_tab_t ROM_TAB = build_rom();

  logic [AW-1:0] data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= ROM_TAB[addr];
    end
  end

  assign data = data_r;

endmodule

### rtl/vector_angle_by_tangent_table.sv
// path from input beat to result: input register, divider cells, table register, output register
// throughput: one beat per cycle unless stalled; set by the chain of divider cells, one quotient bit each
// the input, divider, table and output registers all advance together; a stalled result
// freezes the whole pipeline until it is taken
// reset: synchronous active-low, clears all stage valids; the angle table is constant
module vector_angle_by_tangent_table #(
  parameter int ANGLE_STEPS = 1024,
  parameter int TABLE_SIZE  = 1024,
  parameter int COORD_BITS  = 21
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [vatt_pkg::IN_W-1:0]    in_vec_x,
  input  logic signed [vatt_pkg::IN_W-1:0]    in_vec_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [vatt_pkg::ANGLE_W-1:0]        out_angle
);

  localparam int QB    = $clog2(TABLE_SIZE + 1);
  localparam int NUM_W = COORD_BITS + QB;
  localparam int AW    = $clog2(ANGLE_STEPS);
  localparam int IDX_W = $clog2(TABLE_SIZE + 2);

  logic                  en;

  logic [QB:0]           v_s;
  logic [NUM_W-1:0]      rem_s  [QB+1];
  logic [COORD_BITS-1:0] den_s  [QB+1];
  logic [QB-1:0]         q_s    [QB+1];
  vatt_pkg::vatt_side_t  side_s [QB+1];

  logic [AW-1:0]         rom_data;
  logic                  v_rom_r;
  vatt_pkg::vatt_side_t  side_rom_r;

  logic [AW-1:0]                 base;
  logic [AW-1:0]                 res;
  logic [vatt_pkg::ANGLE_W-1:0]  angle_nxt;
  logic                          out_valid_r;
  logic [vatt_pkg::ANGLE_W-1:0]  angle_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  vatt_prep #(
    .CB    (COORD_BITS),
    .T     (TABLE_SIZE),
    .NUM_W (NUM_W)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_vec_x (in_vec_x),
    .in_vec_y (in_vec_y),
    .v_o      (v_s[0]),
    .num_o    (rem_s[0]),
    .den_o    (den_s[0]),
    .side_o   (side_s[0])
  );

  assign q_s[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    vatt_div_cell #(
      .NUM_W (NUM_W),
      .DEN_W (COORD_BITS),
      .QB    (QB),
      .BIT   (QB - 1 - i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (v_s[i]),
      .rem_i  (rem_s[i]),
      .den_i  (den_s[i]),
      .q_i    (q_s[i]),
      .side_i (side_s[i]),
      .v_o    (v_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .den_o  (den_s[i+1]),
      .q_o    (q_s[i+1]),
      .side_o (side_s[i+1])
    );
  end

  vatt_rom #(
    .ANGLE_STEPS (ANGLE_STEPS),
    .TABLE_SIZE  (TABLE_SIZE),
    .AW          (AW),
    .IDX_W       (IDX_W)
  ) u_rom (
    .clk  (clk),
    .en   (en),
    .addr (IDX_W'(q_s[QB])),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rom_r <= 1'b0;
    end else if (en) begin
      v_rom_r <= v_s[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_rom_r <= side_s[QB];
    end
  end

  // wrap modulo the turn falls out of the AW-bit add
  always_comb begin
    base = AW'(side_rom_r.quad) << (AW - 2);
    res  = side_rom_r.sub ? base - rom_data : base + rom_data;
    angle_nxt = side_rom_r.zero ? vatt_pkg::ZERO_ANGLE : vatt_pkg::ANGLE_W'(res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_rom_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v_s, v_rom_r}))
    else $error("pipeline moved while stalled");

  a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_s[0])
    else $error("accepted beat lost at the first stage");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_s[0] |-> den_s[0] != '0)
    else $error("zero divisor entered the divider");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_s[QB] |-> q_s[QB] <= QB'(TABLE_SIZE))
    else $error("quotient beyond table range");

endmodule
